### src/dssg_pkg.sv
// ----------------------------------------------------------------------------
// dssg_pkg
// Shared types, constants and the quarter-wave sine table of the waveform
// source generator.
// ----------------------------------------------------------------------------
package dssg_pkg;

    localparam int VOLTAGE_BITS     = 16;
    localparam int TIME_BITS        = 32;
    localparam int CFG_DATA_BITS    = 32;
    localparam int CFG_INDEX_BITS   = 3;
    localparam int SINE_TABLE_DEPTH = 1024;
    localparam int ROM_ADDR_BITS    = $clog2(SINE_TABLE_DEPTH);
    localparam int SINE_BITS        = 15;
    localparam int DIV_STAGES       = TIME_BITS;
    localparam int SINE_STAGES      = 5;

    // phase offset: floor((ph * 2^32 + 180) / 360) = ph * PH_WHOLE + floor((32 ph + 22) / 45)
    localparam int          PH_BITS   = 9;
    localparam logic [23:0] PH_WHOLE  = 24'd11930464;
    localparam logic [14:0] PH_RECIP  = 15'd23302;
    localparam int          PH_SHIFT  = 20;
    localparam logic [13:0] PH_BIAS   = 14'd22;

    typedef enum logic [1:0] {
        MODE_DC     = 2'd0,
        MODE_SINE   = 2'd1,
        MODE_SQUARE = 2'd2,
        MODE_SPARE  = 2'd3
    } mode_t;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_SOURCE_MODE    = 3'd0,
        REG_LEVEL_A        = 3'd1,
        REG_LEVEL_B        = 3'd2,
        REG_FREQUENCY_STEP = 3'd3,
        REG_PHASE_DEGREES  = 3'd4,
        REG_ON_TIME        = 3'd5,
        REG_PERIOD_TICKS   = 3'd6,
        REG_UNUSED         = 3'd7
    } reg_index_t;

    typedef logic [SINE_BITS-1:0] sine_rom_t [SINE_TABLE_DEPTH];

    localparam longint unsigned PI_Q30 = 64'd3373259426;

    typedef longint unsigned taylor_div_t [7];
    localparam taylor_div_t TAYLOR_DIVS = '{64'd6, 64'd20, 64'd42, 64'd72,
                                             64'd110, 64'd156, 64'd210};

    // taylor series of sin in q2.30 at the center of each table cell
    function automatic sine_rom_t build_sine_rom();
        sine_rom_t      rom;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint          sum;
        longint          v;
        for (int k = 0; k < SINE_TABLE_DEPTH; k++)
        begin
            x    = ((64'(2 * k) + 64'd1) * PI_Q30) / 64'(4 * SINE_TABLE_DEPTH);
            x2   = (x * x) >> 30;
            term = x;
            sum  = longint'(x);
            for (int n = 1; n <= 7; n++)
            begin
                term = ((term * x2) >> 30) / TAYLOR_DIVS[n-1];
                if (n % 2 == 1)
                    sum = sum - longint'(term);
                else
                    sum = sum + longint'(term);
            end
            if (sum < 0)
                sum = 0;
            v = longint'((longint'(unsigned'(sum)) * 32767 + (64'd1 << 29)) >>> 30);
            if (v > 32767)
                v = 32767;
            rom[k] = SINE_BITS'(v);
        end
        return rom;
    endfunction

endpackage

### src/dssg_in_if.sv
// ----------------------------------------------------------------------------
// dssg_in_if
// Time tick request channel.
// ----------------------------------------------------------------------------
interface dssg_in_if;
    import dssg_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [TIME_BITS-1:0] time_tick;

    modport source (output valid, output time_tick, input ready);
    modport sink   (input valid, input time_tick, output ready);
endinterface

### src/dssg_out_if.sv
// ----------------------------------------------------------------------------
// dssg_out_if
// Voltage result channel.
// ----------------------------------------------------------------------------
interface dssg_out_if;
    import dssg_pkg::*;

    logic                           valid;
    logic                           ready;
    logic signed [VOLTAGE_BITS-1:0] voltage_out;
    logic                           saturated;

    modport source (output valid, output voltage_out, output saturated, input ready);
    modport sink   (input valid, input voltage_out, input saturated, output ready);
endinterface

### src/dc_sine_square_source_generator_unit.sv
// ----------------------------------------------------------------------------
// dc_sine_square_source_generator_unit
// Waveform voltage source: dc, sine or square level at each time tick.
// ----------------------------------------------------------------------------
// Takes one time tick per cycle while the output is not stalled and returns one
// voltage per tick, in order. The pipe depth is set by the square path, which
// finds (t-1) mod period with one restoring step per stage over 32 stages; the
// sine path (multiply, phase add, table read, scale, saturate) runs alongside
// it and is delayed to match. The whole pipe holds while the output is stalled.
// Configuration must be written only while the pipe is empty; the block does not enforce it.
module dc_sine_square_source_generator_unit (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [dssg_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [dssg_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    dssg_in_if.sink                              in_ch,
    dssg_out_if.source                           out_ch
);
    import dssg_pkg::*;

    localparam sine_rom_t SINE_ROM = build_sine_rom();
    localparam logic signed [VOLTAGE_BITS+2:0] V_HI = (VOLTAGE_BITS+3)'((1 << (VOLTAGE_BITS-1)) - 1);
    localparam logic signed [VOLTAGE_BITS+2:0] V_LO = -V_HI - (VOLTAGE_BITS+3)'(1);

    // configuration
    mode_t                          mode_reg;
    logic signed [VOLTAGE_BITS-1:0] level_a_reg;
    logic signed [VOLTAGE_BITS-1:0] level_b_reg;
    logic [TIME_BITS-1:0]           freq_reg;
    logic [PH_BITS-1:0]             phase_reg;
    logic [TIME_BITS-1:0]           on_time_reg;
    logic [TIME_BITS-1:0]           period_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= MODE_DC;
            level_a_reg <= '0;
            level_b_reg <= '0;
            freq_reg    <= '0;
            phase_reg   <= '0;
            on_time_reg <= '0;
            period_reg  <= '0;
        end
        else if (cfg_we)
        begin
            unique case (reg_index_t'(cfg_index))
                REG_SOURCE_MODE:    mode_reg    <= mode_t'(cfg_data[1:0]);
                REG_LEVEL_A:        level_a_reg <= cfg_data[VOLTAGE_BITS-1:0];
                REG_LEVEL_B:        level_b_reg <= cfg_data[VOLTAGE_BITS-1:0];
                REG_FREQUENCY_STEP: freq_reg    <= cfg_data[TIME_BITS-1:0];
                REG_PHASE_DEGREES:  phase_reg   <= cfg_data[PH_BITS-1:0];
                REG_ON_TIME:        on_time_reg <= cfg_data[TIME_BITS-1:0];
                REG_PERIOD_TICKS:   period_reg  <= cfg_data[TIME_BITS-1:0];
                default:            ;
            endcase
        end
    end

    // pipeline control: everything moves together unless the output is held
    logic adv;
    logic v_reg [0:DIV_STAGES];
    logic out_valid_reg;

    assign adv         = !out_valid_reg || out_ch.ready;
    assign in_ch.ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= DIV_STAGES; i++)
                v_reg[i] <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            v_reg[0] <= in_ch.valid;
            for (int i = 1; i <= DIV_STAGES; i++)
                v_reg[i] <= v_reg[i-1];
            out_valid_reg <= v_reg[DIV_STAGES];
        end
    end

    // square path: restoring remainder of (t-1) by the period, one bit per stage
    logic [TIME_BITS-1:0] t_reg;
    logic [TIME_BITS-1:0] dvd_reg  [0:DIV_STAGES];
    logic [TIME_BITS-1:0] rem_reg  [0:DIV_STAGES];
    logic                 tz_reg   [0:DIV_STAGES];
    logic [TIME_BITS-1:0] rem_next [1:DIV_STAGES];
    logic [TIME_BITS:0]   trial    [1:DIV_STAGES];

    always_comb
    begin
        for (int i = 1; i <= DIV_STAGES; i++)
        begin
            trial[i] = {rem_reg[i-1], dvd_reg[i-1][TIME_BITS-1]};
            if (trial[i] >= {1'b0, period_reg})
                rem_next[i] = TIME_BITS'(trial[i] - {1'b0, period_reg});
            else
                rem_next[i] = trial[i][TIME_BITS-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            t_reg      <= in_ch.time_tick;
            dvd_reg[0] <= in_ch.time_tick - TIME_BITS'(1);
            rem_reg[0] <= '0;
            tz_reg[0]  <= (in_ch.time_tick == '0);
            for (int i = 1; i <= DIV_STAGES; i++)
            begin
                dvd_reg[i] <= {dvd_reg[i-1][TIME_BITS-2:0], 1'b0};
                rem_reg[i] <= rem_next[i];
                tz_reg[i]  <= tz_reg[i-1];
            end
        end
    end

    // sine path
    logic [TIME_BITS-1:0]              s1_prod_reg;
    logic [TIME_BITS-1:0]              s1_poff_reg;
    logic [ROM_ADDR_BITS+1:0]          s2_idx_reg;
    logic [SINE_BITS-1:0]              s3_rom_reg;
    logic                              s3_neg_reg;
    logic signed [VOLTAGE_BITS+SINE_BITS+1:0] s4_prod_reg;
    logic signed [VOLTAGE_BITS-1:0]    sd_volt_reg [SINE_STAGES:DIV_STAGES];
    logic                              sd_sat_reg  [SINE_STAGES:DIV_STAGES];

    logic [PH_BITS+23:0]               ph_whole;
    logic [13:0]                       ph_frac_in;
    logic [28:0]                       ph_frac_prod;
    logic [TIME_BITS-1:0]              acc;
    logic [ROM_ADDR_BITS-1:0]          rom_addr;
    logic signed [SINE_BITS+1:0]       s_val;
    logic signed [VOLTAGE_BITS+SINE_BITS+1:0] rounded;
    logic signed [VOLTAGE_BITS+2:0]    scaled;
    logic signed [VOLTAGE_BITS+2:0]    sum;
    logic signed [VOLTAGE_BITS-1:0]    sine_volt;
    logic                              sine_sat;

    always_comb
    begin
        ph_whole     = (PH_BITS+24)'(phase_reg) * (PH_BITS+24)'(PH_WHOLE);
        ph_frac_in   = {phase_reg, 5'd0} + PH_BIAS;
        ph_frac_prod = 29'(ph_frac_in) * 29'(PH_RECIP);
        acc          = s1_prod_reg + s1_poff_reg;
        // odd quadrants walk the table backward
        rom_addr     = s2_idx_reg[ROM_ADDR_BITS] ? ~s2_idx_reg[ROM_ADDR_BITS-1:0]
                                                 : s2_idx_reg[ROM_ADDR_BITS-1:0];
        s_val        = s3_neg_reg ? -$signed({2'b00, s3_rom_reg})
                                  :  $signed({2'b00, s3_rom_reg});
        rounded      = s4_prod_reg + (VOLTAGE_BITS+SINE_BITS+2)'(1 << 14);
        scaled       = (VOLTAGE_BITS+3)'(rounded >>> 15);
        sum          = (VOLTAGE_BITS+3)'(level_a_reg) + scaled;
        sine_sat     = (sum > V_HI) || (sum < V_LO);
        if (sum > V_HI)
            sine_volt = V_HI[VOLTAGE_BITS-1:0];
        else if (sum < V_LO)
            sine_volt = V_LO[VOLTAGE_BITS-1:0];
        else
            sine_volt = sum[VOLTAGE_BITS-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_prod_reg <= TIME_BITS'(freq_reg * t_reg);
            s1_poff_reg <= ph_whole[TIME_BITS-1:0]
                           + TIME_BITS'(ph_frac_prod >> PH_SHIFT);
            s2_idx_reg  <= acc[TIME_BITS-1 -: ROM_ADDR_BITS+2];
            s3_rom_reg  <= SINE_ROM[rom_addr];
            s3_neg_reg  <= s2_idx_reg[ROM_ADDR_BITS+1];
            s4_prod_reg <= (VOLTAGE_BITS+SINE_BITS+2)'(level_b_reg)
                           * (VOLTAGE_BITS+SINE_BITS+2)'(s_val);
            sd_volt_reg[SINE_STAGES] <= sine_volt;
            sd_sat_reg[SINE_STAGES]  <= sine_sat;
            for (int i = SINE_STAGES + 1; i <= DIV_STAGES; i++)
            begin
                sd_volt_reg[i] <= sd_volt_reg[i-1];
                sd_sat_reg[i]  <= sd_sat_reg[i-1];
            end
        end
    end

    // output stage
    logic [TIME_BITS-1:0]           ton;
    logic                           sq_on;
    logic signed [VOLTAGE_BITS-1:0] volt_next;
    logic                           sat_next;
    logic signed [VOLTAGE_BITS-1:0] volt_reg;
    logic                           sat_reg;

    always_comb
    begin
        ton   = (on_time_reg < period_reg) ? on_time_reg : period_reg;
        sq_on = !tz_reg[DIV_STAGES] && (period_reg != '0)
                && (rem_reg[DIV_STAGES] < ton);
        unique case (mode_reg)
            MODE_SINE:
            begin
                volt_next = sd_volt_reg[DIV_STAGES];
                sat_next  = sd_sat_reg[DIV_STAGES];
            end
            MODE_SQUARE:
            begin
                volt_next = sq_on ? level_a_reg : level_b_reg;
                sat_next  = 1'b0;
            end
            default:
            begin
                volt_next = level_a_reg;
                sat_next  = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            volt_reg <= volt_next;
            sat_reg  <= sat_next;
        end
    end

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.voltage_out = volt_reg;
    assign out_ch.saturated   = sat_reg;

    a_sat_only_sine: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.saturated |-> mode_reg == MODE_SINE)
        else $error("saturation flagged outside sine mode");

    a_dc_level: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && (mode_reg == MODE_DC || mode_reg == MODE_SPARE)
        |-> out_ch.voltage_out == level_a_reg)
        else $error("dc result differs from level_a");

    a_entry: assert property (@(posedge clk) disable iff (!rst_n)
        in_ch.valid && in_ch.ready |=> v_reg[0])
        else $error("accepted request not captured");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(v_reg[DIV_STAGES]))
        else $error("pipe moved while output held");

endmodule

### tb/sv/dssg_voltage_checker.sv
// ----------------------------------------------------------------------------
// dssg_voltage_checker
// Watches the time tick and voltage channels and the register port, works out
// the voltage due for each accepted tick and compares it with what comes out.
// ----------------------------------------------------------------------------
module dssg_voltage_checker
    import dssg_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data,
    dssg_in_if                        in_ch,
    dssg_out_if                       out_ch,
    output int                        fail_count,
    output int                        pending,
    output int                        sat_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic signed [VOLTAGE_BITS-1:0] voltage;
        logic                           saturated;
    } voltage_t;

    voltage_t expected_voltages [$];
    int       quarter_sine [SINE_TABLE_DEPTH];

    mode_t                          mode_q;
    logic signed [VOLTAGE_BITS-1:0] level_a_q;
    logic signed [VOLTAGE_BITS-1:0] level_b_q;
    logic [31:0]                    freq_q;
    logic [8:0]                     phase_q;
    logic [31:0]                    on_q;
    logic [31:0]                    period_q;

    initial
    begin
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint          acc;
        longint          rounded;
        for (int k = 0; k < SINE_TABLE_DEPTH; k++)
        begin
            x    = ((2 * longint'(k) + 1) * PI_Q30) / (4 * SINE_TABLE_DEPTH);
            x2   = (x * x) >> 30;
            term = x;
            acc  = longint'(x);
            for (int n = 1; n <= 7; n++)
            begin
                term = ((term * x2) >> 30) / longint'((2 * n) * (2 * n + 1));
                acc  = (n % 2 == 1) ? acc - longint'(term) : acc + longint'(term);
            end
            if (acc < 0)
                acc = 0;
            rounded = (acc * 32767 + (longint'(1) << 29)) >>> 30;
            quarter_sine[k] = (rounded > 32767) ? 32767 : int'(rounded);
        end
    end

    function automatic voltage_t predict_voltage(logic [31:0] t);
        voltage_t        res;
        longint unsigned poff;
        logic [31:0]     acc;
        logic [1:0]      quad;
        logic [9:0]      entry;
        longint          s;
        longint          total;
        logic [31:0]     on_clamped;
        logic            on;
        res.voltage   = level_a_q;
        res.saturated = 1'b0;
        if (mode_q == MODE_SINE)
        begin
            poff  = ((longint'(phase_q) << 32) + 180) / 360;
            acc   = 32'(longint'(freq_q) * longint'(t) + poff);
            quad  = acc[31:30];
            entry = acc[29:20];
            s     = quad[0] ? quarter_sine[SINE_TABLE_DEPTH - 1 - entry] : quarter_sine[entry];
            if (quad[1])
                s = -s;
            total = longint'(level_a_q) + ((longint'(level_b_q) * s + 16384) >>> 15);
            if (total > 32767)
            begin
                total = 32767;
                res.saturated = 1'b1;
            end
            else if (total < -32768)
            begin
                total = -32768;
                res.saturated = 1'b1;
            end
            res.voltage = VOLTAGE_BITS'(total);
        end
        else if (mode_q == MODE_SQUARE)
        begin
            on = 1'b0;
            if (t != 0 && period_q != 0)
            begin
                on_clamped = (on_q < period_q) ? on_q : period_q;
                on = ((t - 32'd1) % period_q) < on_clamped;
            end
            if (!on)
                res.voltage = level_b_q;
        end
        return res;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("[%0t] mismatch %s: got %0d, expected %0d", $realtime, what, got, want);
        fail_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        voltage_t want;
        if (!rst_n)
        begin
            mode_q    <= MODE_DC;
            level_a_q <= '0;
            level_b_q <= '0;
            freq_q    <= '0;
            phase_q   <= '0;
            on_q      <= '0;
            period_q  <= '0;
        end
        else
        begin
            if (in_ch.valid && in_ch.ready)
                expected_voltages = {expected_voltages, predict_voltage(in_ch.time_tick)};
            if (out_ch.valid && out_ch.ready)
            begin
                if (out_ch.saturated)
                    sat_seen++;
                if (expected_voltages.size() == 0)
                    report_mismatch("unexpected result, voltage", out_ch.voltage_out, 0);
                else
                begin
                    want = expected_voltages.pop_front();
                    if (out_ch.voltage_out !== want.voltage)
                        report_mismatch("voltage_out", out_ch.voltage_out, want.voltage);
                    if (out_ch.saturated !== want.saturated)
                        report_mismatch("saturated", out_ch.saturated, want.saturated);
                end
            end
            if (cfg_we)
            begin
                case (reg_index_t'(cfg_index))
                    REG_SOURCE_MODE:    mode_q    <= mode_t'(cfg_data[1:0]);
                    REG_LEVEL_A:        level_a_q <= cfg_data[15:0];
                    REG_LEVEL_B:        level_b_q <= cfg_data[15:0];
                    REG_FREQUENCY_STEP: freq_q    <= cfg_data;
                    REG_PHASE_DEGREES:  phase_q   <= cfg_data[8:0];
                    REG_ON_TIME:        on_q      <= cfg_data;
                    REG_PERIOD_TICKS:   period_q  <= cfg_data;
                    default: ;
                endcase
            end
        end
        pending <= expected_voltages.size();
    end

    initial
    begin
        fail_count = 0;
        pending    = 0;
        sat_seen   = 0;
    end

endmodule

### tb/sv/tb_dc_sine_square_source_generator_unit.sv
// ----------------------------------------------------------------------------
// tb_dc_sine_square_source_generator_unit
// Drives time ticks and register settings into the waveform source through
// directed dc, sine and square cases and then random settings and ticks under
// varying backpressure; the checker module judges every voltage.
// ----------------------------------------------------------------------------
module tb_dc_sine_square_source_generator_unit;
    import dssg_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DRAIN_CYCLES = 40;
    localparam int STALL_LIMIT  = 5000;
    localparam int HOLD_CYCLES  = 300;

    logic                      clk;
    logic                      rst_n;
    logic                      cfg_we;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [CFG_DATA_BITS-1:0]  cfg_data;
    int                        fail_count;
    int                        pending;
    int                        sat_seen;
    int                        send_idle;
    int                        recv_idle;
    bit                        hold_request;
    int                        ticks_sent;
    int                        settings_used;
    int                        quiet_cycles;

    dssg_in_if  in_ch ();
    dssg_out_if out_ch ();

    dc_sine_square_source_generator_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    dssg_voltage_checker checker_inst (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_ch      (in_ch),
        .out_ch     (out_ch),
        .fail_count (fail_count),
        .pending    (pending),
        .sat_seen   (sat_seen)
    );

    initial
        clk = 1'b0;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // receiver side, with one long hold-off
    initial
    begin
        out_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES - 1)
                    @(posedge clk);
            end
            else
                out_ch.ready <= ($urandom_range(99) >= recv_idle);
        end
    end

    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic write_reg(reg_index_t idx, logic [31:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic send_tick(logic [31:0] t);
        while ($urandom_range(99) < send_idle)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.time_tick <= t;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        ticks_sent++;
    endtask

    // ends a batch: lowers valid and lets the pipe empty before any write
    task automatic drain_pipe();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
    endtask

    task automatic apply_setting(mode_t m, logic [15:0] a, logic [15:0] b,
                                 logic [31:0] f, logic [8:0] ph,
                                 logic [31:0] on, logic [31:0] per);
        write_reg(REG_SOURCE_MODE, 32'(m));
        write_reg(REG_LEVEL_A, 32'(a));
        write_reg(REG_LEVEL_B, 32'(b));
        write_reg(REG_FREQUENCY_STEP, f);
        write_reg(REG_PHASE_DEGREES, 32'(ph));
        write_reg(REG_ON_TIME, on);
        write_reg(REG_PERIOD_TICKS, per);
        settings_used++;
    endtask

    function automatic logic [31:0] random_tick();
        return ($urandom_range(2) == 0) ? 32'($urandom_range(300)) : $urandom;
    endfunction

    initial
    begin
        mode_t       m;
        logic [31:0] per;
        in_ch.valid     <= 1'b0;
        in_ch.time_tick <= '0;
        cfg_we          <= 1'b0;
        cfg_index       <= '0;
        cfg_data        <= '0;
        rst_n           <= 1'b0;
        send_idle     = 0;
        recv_idle     = 0;
        hold_request  = 1'b0;
        ticks_sent    = 0;
        settings_used = 0;
        quiet_cycles  = 0;
        repeat (8)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // dc extremes and the spare mode, which falls back to dc
        apply_setting(MODE_DC, 16'h7fff, 16'h8000, 32'd0, 9'd0, 32'd0, 32'd0);
        send_tick(32'd0);
        send_tick(32'hffff_ffff);
        drain_pipe();
        apply_setting(MODE_SPARE, 16'h8000, 16'h7fff, 32'hffff_ffff, 9'd511, 32'd5, 32'd9);
        send_tick(32'd1);
        send_tick(32'haaaa_5555);
        drain_pipe();
        write_reg(REG_UNUSED, 32'hffff_ffff);

        // sine: full scale, clipping both ways, odd phases
        apply_setting(MODE_SINE, 16'h0000, 16'h7fff, 32'h0100_0000, 9'd90, 32'd0, 32'd0);
        for (int i = 0; i < 4; i++)
            send_tick(32'(i * 64));
        drain_pipe();
        apply_setting(MODE_SINE, 16'h7fff, 16'h7fff, 32'h4000_0000, 9'd359, 32'd0, 32'd0);
        send_tick(32'd0);
        send_tick(32'd1);
        drain_pipe();
        apply_setting(MODE_SINE, 16'h8000, 16'h8000, 32'hffff_ffff, 9'd360, 32'd0, 32'd0);
        send_tick(32'd0);
        send_tick(32'hffff_ffff);
        send_tick(32'd3);
        drain_pipe();

        // square: zero period, clamped on time, tick zero, ordinary wave
        apply_setting(MODE_SQUARE, 16'h1234, 16'hedcb, 32'd0, 9'd0, 32'd3, 32'd0);
        send_tick(32'd5);
        drain_pipe();
        apply_setting(MODE_SQUARE, 16'h7fff, 16'h8000, 32'd0, 9'd0, 32'hffff_ffff, 32'd7);
        send_tick(32'd0);
        send_tick(32'd7);
        drain_pipe();
        apply_setting(MODE_SQUARE, 16'h0100, 16'hff00, 32'd0, 9'd0, 32'd3, 32'd10);
        send_tick(32'd3);
        send_tick(32'd4);
        send_tick(32'd11);
        send_tick(32'hffff_ffff);
        drain_pipe();
        apply_setting(MODE_SQUARE, 16'h0001, 16'hffff, 32'd0, 9'd0,
                      32'hffff_fffe, 32'hffff_ffff);
        send_tick(32'hffff_ffff);
        send_tick(32'hffff_fffe);
        drain_pipe();

        for (int batch = 0; batch < 26; batch++)
        begin
            if (batch < 9)
            begin
                send_idle = 24;
                recv_idle = 73;
            end
            else if (batch < 18)
            begin
                send_idle = 73;
                recv_idle = 24;
            end
            else
            begin
                send_idle = 0;
                recv_idle = 0;
            end
            m   = mode_t'($urandom_range(3));
            per = ($urandom_range(3) == 0) ? $urandom : 32'($urandom_range(64));
            apply_setting(m, 16'($urandom), 16'($urandom),
                          ($urandom_range(1) == 0) ? $urandom : 32'($urandom_range(1 << 24)),
                          ($urandom_range(7) == 0) ? 9'($urandom) : 9'($urandom_range(359)),
                          ($urandom_range(3) == 0) ? $urandom : 32'($urandom_range(70)),
                          per);
            if (batch == 20)
                hold_request = 1'b1;
            for (int i = 0; i < 55; i++)
                send_tick(random_tick());
            drain_pipe();
        end

        $display("tb: %0d ticks over %0d register settings, %0d clipped sine results",
                 ticks_sent, settings_used, sat_seen);
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

### sim.f
src/dssg_pkg.sv
src/dssg_in_if.sv
src/dssg_out_if.sv
src/dc_sine_square_source_generator_unit.sv
tb/sv/dssg_voltage_checker.sv
tb/sv/tb_dc_sine_square_source_generator_unit.sv
